// ----- rtl/tpce_pkg.sv -----
// shared types, constants and microcode table of the text position command encoder
package tpce_pkg;

  localparam int STACK_DEPTH_DEF = 5;
  localparam int SCREEN_RES_DEF  = 100;

  localparam int POS_W      = 24;
  localparam int OP_W       = 3;
  localparam int CODE_W     = 8;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_TDATA_W = 32;
  localparam int STATUS_W   = 2;
  localparam int PC_W       = 5;

  localparam int ASPECT_FRAC = 12;
  localparam int ROW_SPAN    = 1023 - 10;
  localparam int ROW_DEN     = 11;
  localparam int DIVISOR_W   = CFG_W + 5;
  localparam int POS_MAX     = 8388607;
  localparam int POS_MIN     = -8388608;

  localparam logic [CFG_W-1:0] RESOLUTION_RST = 16'd972;
  localparam logic [CFG_W-1:0] ASPECT_RST     = 16'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ASPECT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVF = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNF = 2'd2;

  localparam logic [CODE_W-1:0] CH_Y_ROW  = 8'h79;
  localparam logic [CODE_W-1:0] CH_X_REL  = 8'h58;
  localparam logic [CODE_W-1:0] CH_X_ABS  = 8'h78;
  localparam logic [CODE_W-1:0] CH_CHAR   = 8'h63;
  localparam logic [CODE_W-1:0] CH_ZERO   = 8'h30;

  localparam logic [PC_W-1:0] PC_IDLE   = 5'd0;
  localparam logic [PC_W-1:0] PC_DISP   = 5'd1;
  localparam logic [PC_W-1:0] PC_PUSH   = 5'd2;
  localparam logic [PC_W-1:0] PC_POP    = 5'd3;
  localparam logic [PC_W-1:0] PC_SETH   = 5'd4;
  localparam logic [PC_W-1:0] PC_MOVH   = 5'd5;
  localparam logic [PC_W-1:0] PC_SETV   = 5'd6;
  localparam logic [PC_W-1:0] PC_MOVV   = 5'd7;
  localparam logic [PC_W-1:0] PC_NEWL   = 5'd8;
  localparam logic [PC_W-1:0] PC_PRINT  = 5'd9;
  localparam logic [PC_W-1:0] PC_OVF    = 5'd10;
  localparam logic [PC_W-1:0] PC_UNF    = 5'd11;
  localparam logic [PC_W-1:0] PC_MULX   = 5'd12;
  localparam logic [PC_W-1:0] PC_NUMX   = 5'd13;
  localparam logic [PC_W-1:0] PC_DIVX   = 5'd14;
  localparam logic [PC_W-1:0] PC_WAITX  = 5'd15;
  localparam logic [PC_W-1:0] PC_NUMY   = 5'd16;
  localparam logic [PC_W-1:0] PC_DIVY   = 5'd17;
  localparam logic [PC_W-1:0] PC_WAITY  = 5'd18;
  localparam logic [PC_W-1:0] PC_YCHK   = 5'd19;
  localparam logic [PC_W-1:0] PC_YCMD   = 5'd20;
  localparam logic [PC_W-1:0] PC_YHI    = 5'd21;
  localparam logic [PC_W-1:0] PC_YLO    = 5'd22;
  localparam logic [PC_W-1:0] PC_XCHK   = 5'd23;
  localparam logic [PC_W-1:0] PC_XSCMD  = 5'd24;
  localparam logic [PC_W-1:0] PC_XSDX   = 5'd25;
  localparam logic [PC_W-1:0] PC_XSCODE = 5'd26;
  localparam logic [PC_W-1:0] PC_XLCMD  = 5'd27;
  localparam logic [PC_W-1:0] PC_XLHI   = 5'd28;
  localparam logic [PC_W-1:0] PC_XLLO   = 5'd29;
  localparam logic [PC_W-1:0] PC_XLC    = 5'd30;
  localparam logic [PC_W-1:0] PC_XLCODE = 5'd31;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_NO_IN,
    COND_DISPATCH,
    COND_FULL,
    COND_EMPTY,
    COND_CODE_ZERO,
    COND_OUT_BUSY,
    COND_DIV_BUSY,
    COND_Y_SAME,
    COND_X_LONG
  } cond_e;

  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_LOAD_IN,
    ACT_PUSH,
    ACT_POP,
    ACT_SETH,
    ACT_MOVH,
    ACT_SETV,
    ACT_MOVV,
    ACT_NEWL,
    ACT_SUM,
    ACT_MULX,
    ACT_NUMX,
    ACT_DIVX,
    ACT_STOREX,
    ACT_NUMY,
    ACT_DIVY,
    ACT_STOREY,
    ACT_LASTY,
    ACT_LASTX
  } act_e;

  typedef enum logic [3:0] {
    BS_ZERO,
    BS_CH_Y,
    BS_YHI,
    BS_YLO,
    BS_CH_XREL,
    BS_DX,
    BS_CODE,
    BS_CH_XABS,
    BS_XHI,
    BS_XLO,
    BS_CH_C
  } bsel_e;

  typedef struct packed {
    cond_e                cond;
    logic [PC_W-1:0]      jmp;
    logic [PC_W-1:0]      nxt;
    act_e                 act;
    logic                 emit;
    bsel_e                bsel;
    logic                 last;
    logic [STATUS_W-1:0]  status;
    logic                 in_rdy;
  } ucode_t;

  typedef struct packed {
    act_e                 act;
    logic                 emit;
    bsel_e                bsel;
    logic                 last;
    logic [STATUS_W-1:0]  status;
    logic                 in_rdy;
  } ctl_t;

  typedef struct packed {
    logic             in_valid;
    logic             full;
    logic             empty;
    logic             code_zero;
    logic             out_busy;
    logic             div_busy;
    logic             y_same;
    logic             x_long;
    logic [OP_W-1:0]  op;
  } flags_t;

  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    w.cond   = COND_NEVER;
    w.jmp    = PC_IDLE;
    w.nxt    = PC_IDLE;
    w.act    = ACT_NONE;
    w.emit   = 1'b0;
    w.bsel   = BS_ZERO;
    w.last   = 1'b0;
    w.status = ST_OK;
    w.in_rdy = 1'b0;
    unique case (pc)
      PC_IDLE: begin
        w.cond = COND_NO_IN; w.jmp = PC_IDLE; w.act = ACT_LOAD_IN;
        w.nxt = PC_DISP; w.in_rdy = 1'b1;
      end
      PC_DISP:  begin w.cond = COND_DISPATCH; w.jmp = PC_PUSH; end
      PC_PUSH:  begin w.cond = COND_FULL; w.jmp = PC_OVF; w.act = ACT_PUSH; end
      PC_POP:   begin w.cond = COND_EMPTY; w.jmp = PC_UNF; w.act = ACT_POP; end
      PC_SETH:  w.act = ACT_SETH;
      PC_MOVH:  w.act = ACT_MOVH;
      PC_SETV:  w.act = ACT_SETV;
      PC_MOVV:  w.act = ACT_MOVV;
      PC_NEWL:  w.act = ACT_NEWL;
      PC_PRINT: begin
        w.cond = COND_CODE_ZERO; w.jmp = PC_IDLE; w.act = ACT_SUM; w.nxt = PC_MULX;
      end
      PC_OVF: begin
        w.cond = COND_OUT_BUSY; w.jmp = PC_OVF; w.emit = 1'b1; w.bsel = BS_ZERO;
        w.last = 1'b1; w.status = ST_OVF;
      end
      PC_UNF: begin
        w.cond = COND_OUT_BUSY; w.jmp = PC_UNF; w.emit = 1'b1; w.bsel = BS_ZERO;
        w.last = 1'b1; w.status = ST_UNF;
      end
      PC_MULX:  begin w.act = ACT_MULX; w.nxt = PC_NUMX; end
      PC_NUMX:  begin w.act = ACT_NUMX; w.nxt = PC_DIVX; end
      PC_DIVX:  begin w.act = ACT_DIVX; w.nxt = PC_WAITX; end
      PC_WAITX: begin
        w.cond = COND_DIV_BUSY; w.jmp = PC_WAITX; w.act = ACT_STOREX; w.nxt = PC_NUMY;
      end
      PC_NUMY:  begin w.act = ACT_NUMY; w.nxt = PC_DIVY; end
      PC_DIVY:  begin w.act = ACT_DIVY; w.nxt = PC_WAITY; end
      PC_WAITY: begin
        w.cond = COND_DIV_BUSY; w.jmp = PC_WAITY; w.act = ACT_STOREY; w.nxt = PC_YCHK;
      end
      PC_YCHK: begin
        w.cond = COND_Y_SAME; w.jmp = PC_XCHK; w.act = ACT_LASTY; w.nxt = PC_YCMD;
      end
      PC_YCMD: begin
        w.cond = COND_OUT_BUSY; w.jmp = PC_YCMD; w.emit = 1'b1; w.bsel = BS_CH_Y;
        w.nxt = PC_YHI;
      end
      PC_YHI: begin
        w.cond = COND_OUT_BUSY; w.jmp = PC_YHI; w.emit = 1'b1; w.bsel = BS_YHI;
        w.nxt = PC_YLO;
      end
      PC_YLO: begin
        w.cond = COND_OUT_BUSY; w.jmp = PC_YLO; w.emit = 1'b1; w.bsel = BS_YLO;
        w.nxt = PC_XCHK;
      end
      PC_XCHK: begin w.cond = COND_X_LONG; w.jmp = PC_XLCMD; w.nxt = PC_XSCMD; end
      PC_XSCMD: begin
        w.cond = COND_OUT_BUSY; w.jmp = PC_XSCMD; w.emit = 1'b1; w.bsel = BS_CH_XREL;
        w.nxt = PC_XSDX;
      end
      PC_XSDX: begin
        w.cond = COND_OUT_BUSY; w.jmp = PC_XSDX; w.emit = 1'b1; w.bsel = BS_DX;
        w.nxt = PC_XSCODE;
      end
      PC_XSCODE: begin
        w.cond = COND_OUT_BUSY; w.jmp = PC_XSCODE; w.emit = 1'b1; w.bsel = BS_CODE;
        w.last = 1'b1; w.act = ACT_LASTX;
      end
      PC_XLCMD: begin
        w.cond = COND_OUT_BUSY; w.jmp = PC_XLCMD; w.emit = 1'b1; w.bsel = BS_CH_XABS;
        w.nxt = PC_XLHI;
      end
      PC_XLHI: begin
        w.cond = COND_OUT_BUSY; w.jmp = PC_XLHI; w.emit = 1'b1; w.bsel = BS_XHI;
        w.nxt = PC_XLLO;
      end
      PC_XLLO: begin
        w.cond = COND_OUT_BUSY; w.jmp = PC_XLLO; w.emit = 1'b1; w.bsel = BS_XLO;
        w.nxt = PC_XLC;
      end
      PC_XLC: begin
        w.cond = COND_OUT_BUSY; w.jmp = PC_XLC; w.emit = 1'b1; w.bsel = BS_CH_C;
        w.nxt = PC_XLCODE;
      end
      PC_XLCODE: begin
        w.cond = COND_OUT_BUSY; w.jmp = PC_XLCODE; w.emit = 1'b1; w.bsel = BS_CODE;
        w.last = 1'b1; w.act = ACT_LASTX;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/tpce_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
module tpce_div #(
  parameter int DW = 39,
  parameter int VW = tpce_pkg::DIVISOR_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quotient_o
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [VW-1:0] rem_q, rem_d;
  logic [DW-1:0] quo_q;
  logic [VW-1:0] dvs_q;
  logic [VW:0]   shifted;
  logic          ge;

  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    ge      = shifted >= {1'b0, dvs_q};
    rem_d   = ge ? VW'(shifted - {1'b0, dvs_q}) : VW'(shifted);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_run_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> ##(DW) !busy_q) else $error("divider run length wrong");
`endif

endmodule

// ----- rtl/tpce_ctrl.sv -----
// microcode sequencer: step counter, control rom and conditional jumps
module tpce_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tpce_pkg::flags_t  flags_i,
  output tpce_pkg::ctl_t    ctl_o
);

  logic [tpce_pkg::PC_W-1:0] pc_q, pc_d;
  tpce_pkg::ucode_t          cw;
  logic                      taken;

  always_comb begin
    cw = tpce_pkg::ucode(pc_q);
    unique case (cw.cond)
      tpce_pkg::COND_NEVER:     taken = 1'b0;
      tpce_pkg::COND_NO_IN:     taken = !flags_i.in_valid;
      tpce_pkg::COND_DISPATCH:  taken = 1'b1;
      tpce_pkg::COND_FULL:      taken = flags_i.full;
      tpce_pkg::COND_EMPTY:     taken = flags_i.empty;
      tpce_pkg::COND_CODE_ZERO: taken = flags_i.code_zero;
      tpce_pkg::COND_OUT_BUSY:  taken = flags_i.out_busy;
      tpce_pkg::COND_DIV_BUSY:  taken = flags_i.div_busy;
      tpce_pkg::COND_Y_SAME:    taken = flags_i.y_same;
      tpce_pkg::COND_X_LONG:    taken = flags_i.x_long;
      default:                  taken = 1'b0;
    endcase

    if (cw.cond == tpce_pkg::COND_DISPATCH) begin
      pc_d = cw.jmp + tpce_pkg::PC_W'(flags_i.op);
    end else if (taken) begin
      pc_d = cw.jmp;
    end else begin
      pc_d = cw.nxt;
    end

    ctl_o.act    = taken ? tpce_pkg::ACT_NONE : cw.act;
    ctl_o.emit   = cw.emit && !taken;
    ctl_o.bsel   = cw.bsel;
    ctl_o.last   = cw.last;
    ctl_o.status = cw.status;
    ctl_o.in_rdy = cw.in_rdy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= tpce_pkg::PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.in_rdy && flags_i.in_valid) |=> (pc_q == tpce_pkg::PC_DISP))
    else $error("accepted word not dispatched");
`endif

endmodule

// ----- rtl/tpce_dp.sv -----
// datapath: pen state, origin stack, scaling arithmetic and output register
module tpce_dp #(
  parameter int STACK_DEPTH = tpce_pkg::STACK_DEPTH_DEF,
  parameter int SCREEN_RES  = tpce_pkg::SCREEN_RES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tpce_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tpce_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                s_tvalid_i,
  input  logic [tpce_pkg::IN_TDATA_W-1:0]     s_tdata_i,
  input  logic [tpce_pkg::OP_W-1:0]           s_tuser_i,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  output logic [tpce_pkg::CODE_W-1:0]         m_tdata_o,
  output logic                                m_tlast_o,
  output logic [tpce_pkg::STATUS_W-1:0]       m_tuser_o,
  input  tpce_pkg::ctl_t                      ctl_i,
  output tpce_pkg::flags_t                    flags_o
);

  localparam int PW     = tpce_pkg::POS_W;
  localparam int DEP_W  = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SR2    = 2 * SCREEN_RES;
  localparam int SRW    = $clog2(SR2 + 1);
  localparam int PROD_W = PW + 1 + tpce_pkg::CFG_W + 1;
  localparam int NXW    = PROD_W + SRW + 2;
  localparam int XSH    = tpce_pkg::ASPECT_FRAC + 1;
  localparam int DIV_W  = (NXW - XSH > 37) ? NXW - XSH : 37;
  localparam int VW     = tpce_pkg::DIVISOR_W;
  localparam int QW     = DIV_W + 2;
  localparam int ROWK   = 2 * tpce_pkg::ROW_SPAN;

  localparam logic signed [SRW:0] SR2_S  = (SRW + 1)'(SR2);
  localparam logic signed [12:0]  ROWK_S = 13'(ROWK);

  typedef struct packed {
    logic [PW-1:0] h_org;
    logic [PW-1:0] v_org;
    logic [PW-1:0] h_pos;
    logic [PW-1:0] v_pos;
  } stk_ent_t;

  // configuration
  logic        [tpce_pkg::CFG_W-1:0] res_q, aspect_q;
  logic signed [tpce_pkg::CFG_W-1:0] xoff_q, yoff_q;
  logic        [tpce_pkg::CFG_W-1:0] res_eff;

  // pen state
  logic [PW-1:0]    hpos_q, vpos_q, horg_q, vorg_q;
  logic [PW-1:0]    hpos_d, vpos_d, horg_d, vorg_d;
  logic [DEP_W-1:0] depth_q, depth_d;
  logic [PW-1:0]    lastx_q, lasty_q;
  stk_ent_t         stk_q [STACK_DEPTH];
  logic [DEP_W-1:0] pop_cnt;
  stk_ent_t         pop_ent;

  // input word
  logic [tpce_pkg::OP_W-1:0]   op_q;
  logic [PW-1:0]               mv_q;
  logic [tpce_pkg::CODE_W-1:0] code_q;

  // arithmetic
  logic signed [PW:0]       ax_q, ay_q;
  logic signed [PROD_W-1:0] p_q;
  logic signed [NXW-1:0]    acc_q, numx, numy;
  logic        [NXW-1:0]    mag;
  logic                     neg_q;
  logic signed [PW-1:0]     xr_q, yr_q;
  logic signed [PW:0]       dx;
  logic                     x_short;

  // divider
  logic             div_start, div_busy;
  logic [DIV_W-1:0] div_dvd, div_quo;
  logic [VW-1:0]    div_dvs;
  logic signed [QW-1:0] q_s, q_x, q_y;
  logic signed [PW-1:0] x_sat, y_sat;

  // output register
  logic                          out_valid_q;
  logic [tpce_pkg::CODE_W-1:0]   out_byte_q, out_byte;
  logic                          out_last_q;
  logic [tpce_pkg::STATUS_W-1:0] out_status_q;

  function automatic logic signed [PW-1:0] sat_pos(input logic signed [QW-1:0] v);
    logic signed [PW-1:0] r;
    if (v > QW'(tpce_pkg::POS_MAX)) begin
      r = PW'(tpce_pkg::POS_MAX);
    end else if (v < QW'(tpce_pkg::POS_MIN)) begin
      r = PW'(tpce_pkg::POS_MIN);
    end else begin
      r = v[PW-1:0];
    end
    return r;
  endfunction

  assign res_eff = (res_q == '0) ? tpce_pkg::CFG_W'(1) : res_q;

  always_comb begin
    pop_cnt = depth_q - 1'b1;
    pop_ent = stk_q[pop_cnt[IDX_W-1:0]];

    numx = NXW'(p_q) * NXW'(SR2_S)
         + NXW'($signed({1'b0, res_eff, {tpce_pkg::ASPECT_FRAC{1'b0}}}));
    numy = NXW'(ay_q) * NXW'(ROWK_S)
         + NXW'($signed({1'b0, res_eff})) * NXW'(tpce_pkg::ROW_DEN);
    mag  = acc_q[NXW-1] ? NXW'(-acc_q) : NXW'(acc_q);

    div_start = (ctl_i.act == tpce_pkg::ACT_DIVX) || (ctl_i.act == tpce_pkg::ACT_DIVY);
    if (ctl_i.act == tpce_pkg::ACT_DIVX) begin
      div_dvd = DIV_W'(mag >> XSH);
      div_dvs = VW'(res_eff);
    end else begin
      div_dvd = DIV_W'(mag);
      div_dvs = VW'({5'b0, res_eff} * VW'(2 * tpce_pkg::ROW_DEN));
    end

    q_s   = neg_q ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    q_x   = q_s + QW'(xoff_q);
    q_y   = q_s + QW'(yoff_q);
    x_sat = sat_pos(q_x);
    y_sat = sat_pos(q_y);

    dx      = {xr_q[PW-1], xr_q} - {lastx_q[PW-1], lastx_q};
    x_short = (dx[PW:8] == '0) && (code_q != tpce_pkg::CH_ZERO);
  end

  always_comb begin
    unique case (ctl_i.bsel)
      tpce_pkg::BS_ZERO:    out_byte = '0;
      tpce_pkg::BS_CH_Y:    out_byte = tpce_pkg::CH_Y_ROW;
      tpce_pkg::BS_YHI:     out_byte = yr_q[15:8];
      tpce_pkg::BS_YLO:     out_byte = yr_q[7:0];
      tpce_pkg::BS_CH_XREL: out_byte = tpce_pkg::CH_X_REL;
      tpce_pkg::BS_DX:      out_byte = dx[7:0];
      tpce_pkg::BS_CODE:    out_byte = code_q;
      tpce_pkg::BS_CH_XABS: out_byte = tpce_pkg::CH_X_ABS;
      tpce_pkg::BS_XHI:     out_byte = xr_q[15:8];
      tpce_pkg::BS_XLO:     out_byte = xr_q[7:0];
      tpce_pkg::BS_CH_C:    out_byte = tpce_pkg::CH_CHAR;
      default:              out_byte = '0;
    endcase
  end

  always_comb begin
    hpos_d  = hpos_q;
    vpos_d  = vpos_q;
    horg_d  = horg_q;
    vorg_d  = vorg_q;
    depth_d = depth_q;
    unique case (ctl_i.act)
      tpce_pkg::ACT_PUSH: begin
        depth_d = depth_q + 1'b1;
        horg_d  = hpos_q;
        vorg_d  = vpos_q;
        hpos_d  = '0;
        vpos_d  = '0;
      end
      tpce_pkg::ACT_POP: begin
        depth_d = pop_cnt;
        horg_d  = pop_ent.h_org;
        vorg_d  = pop_ent.v_org;
        hpos_d  = pop_ent.h_pos;
        vpos_d  = pop_ent.v_pos;
      end
      tpce_pkg::ACT_SETH: hpos_d = mv_q;
      tpce_pkg::ACT_MOVH: hpos_d = hpos_q + mv_q;
      tpce_pkg::ACT_SETV: vpos_d = mv_q;
      tpce_pkg::ACT_MOVV: vpos_d = vpos_q + mv_q;
      tpce_pkg::ACT_NEWL: hpos_d = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q    <= tpce_pkg::RESOLUTION_RST;
      aspect_q <= tpce_pkg::ASPECT_RST;
      xoff_q   <= '0;
      yoff_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tpce_pkg::REG_RESOLUTION: res_q    <= cfg_data_i;
        tpce_pkg::REG_ASPECT:     aspect_q <= cfg_data_i;
        tpce_pkg::REG_X_OFFSET:   xoff_q   <= cfg_data_i;
        tpce_pkg::REG_Y_OFFSET:   yoff_q   <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpos_q  <= '0;
      vpos_q  <= '0;
      horg_q  <= '0;
      vorg_q  <= '0;
      depth_q <= '0;
      lastx_q <= '0;
      lasty_q <= '0;
    end else begin
      hpos_q  <= hpos_d;
      vpos_q  <= vpos_d;
      horg_q  <= horg_d;
      vorg_q  <= vorg_d;
      depth_q <= depth_d;
      if (ctl_i.act == tpce_pkg::ACT_LASTX) begin
        lastx_q <= xr_q;
      end
      if (ctl_i.act == tpce_pkg::ACT_LASTY) begin
        lasty_q <= yr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.act == tpce_pkg::ACT_PUSH) begin
      stk_q[depth_q[IDX_W-1:0]] <= '{h_org: horg_q, v_org: vorg_q,
                                     h_pos: hpos_q, v_pos: vpos_q};
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.act)
      tpce_pkg::ACT_LOAD_IN: begin
        op_q   <= s_tuser_i;
        mv_q   <= s_tdata_i[PW-1:0];
        code_q <= s_tdata_i[PW +: tpce_pkg::CODE_W];
      end
      tpce_pkg::ACT_SUM: begin
        ax_q <= {hpos_q[PW-1], hpos_q} + {horg_q[PW-1], horg_q};
        ay_q <= {vpos_q[PW-1], vpos_q} + {vorg_q[PW-1], vorg_q};
      end
      tpce_pkg::ACT_MULX: p_q <= PROD_W'(ax_q) * PROD_W'($signed({1'b0, aspect_q}));
      tpce_pkg::ACT_NUMX: acc_q <= numx;
      tpce_pkg::ACT_NUMY: acc_q <= numy;
      tpce_pkg::ACT_DIVX, tpce_pkg::ACT_DIVY: neg_q <= acc_q[NXW-1];
      tpce_pkg::ACT_STOREX: xr_q <= x_sat;
      tpce_pkg::ACT_STOREY: yr_q <= y_sat;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      out_byte_q   <= out_byte;
      out_last_q   <= ctl_i.last;
      out_status_q <= ctl_i.status;
    end
  end

  tpce_div #(
    .DW (DIV_W),
    .VW (VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  always_comb begin
    flags_o.in_valid  = s_tvalid_i;
    flags_o.full      = depth_q == DEP_W'(STACK_DEPTH);
    flags_o.empty     = depth_q == '0;
    flags_o.code_zero = code_q == '0;
    flags_o.out_busy  = out_valid_q && !m_tready_i;
    flags_o.div_busy  = div_busy;
    flags_o.y_same    = yr_q == lasty_q;
    flags_o.x_long    = !x_short;
    flags_o.op        = op_q;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_byte_q;
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = out_status_q;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEP_W'(STACK_DEPTH)) else $error("stack depth out of range");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.emit |-> (!out_valid_q || m_tready_i)) else $error("output word overwritten");
  a_store_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ctl_i.act == tpce_pkg::ACT_STOREX) || (ctl_i.act == tpce_pkg::ACT_STOREY))
    |-> !div_busy) else $error("quotient taken while divider busy");
`endif

endmodule

// ----- rtl/text_position_command_encoder.sv -----
// top level of the text position command encoder
// motion, push, pop and print of code zero: accept, dispatch and their action state, then idle
// a stack error adds an error state that emits its single error word and waits out output stalls
// print: sum, scale, divide x and y, then emit the bytes, waiting out stalls; DIV_W = 39 at default parameters
// print time is set by the shared restoring divider, one quotient bit per cycle, run for x and y
// reset clears pen state, origins, stack depth and last position and loads register defaults
module text_position_command_encoder #(
  parameter int STACK_DEPTH = tpce_pkg::STACK_DEPTH_DEF,
  parameter int SCREEN_RES  = tpce_pkg::SCREEN_RES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tpce_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tpce_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [tpce_pkg::IN_TDATA_W-1:0] s_axis_tdata,   // motion_value, char_code
  input  logic [tpce_pkg::OP_W-1:0]       s_axis_tuser,   // operation
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [tpce_pkg::CODE_W-1:0]     m_axis_tdata,   // out_byte
  output logic                            m_axis_tlast,
  output logic [tpce_pkg::STATUS_W-1:0]   m_axis_tuser    // status
);

  tpce_pkg::ctl_t   ctl;
  tpce_pkg::flags_t flags;

  tpce_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  tpce_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .SCREEN_RES  (SCREEN_RES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_axis_tvalid),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast),
    .m_tuser_o  (m_axis_tuser),
    .ctl_i      (ctl),
    .flags_o    (flags)
  );

  assign s_axis_tready = ctl.in_rdy;

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for the text position command encoder
module testbench;

  localparam logic [tpce_pkg::OP_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [tpce_pkg::OP_W-1:0] OP_POP     = 3'd1;
  localparam logic [tpce_pkg::OP_W-1:0] OP_SET_H   = 3'd2;
  localparam logic [tpce_pkg::OP_W-1:0] OP_MOVE_H  = 3'd3;
  localparam logic [tpce_pkg::OP_W-1:0] OP_SET_V   = 3'd4;
  localparam logic [tpce_pkg::OP_W-1:0] OP_MOVE_V  = 3'd5;
  localparam logic [tpce_pkg::OP_W-1:0] OP_NEWLINE = 3'd6;
  localparam logic [tpce_pkg::OP_W-1:0] OP_PRINT   = 3'd7;

  localparam int FRAME_DEPTH  = tpce_pkg::STACK_DEPTH_DEF;
  localparam int DEPTH_W      = $clog2(FRAME_DEPTH + 1);
  localparam int DRAIN_CYCLES = 250;
  localparam int STALL_LIMIT  = 5000;

  typedef struct packed {
    logic [tpce_pkg::CODE_W-1:0]   data;
    logic                          last;
    logic [tpce_pkg::STATUS_W-1:0] status;
  } cmd_byte_t;

  typedef struct packed {
    logic signed [tpce_pkg::POS_W-1:0] org_h;
    logic signed [tpce_pkg::POS_W-1:0] org_v;
    logic signed [tpce_pkg::POS_W-1:0] pen_h;
    logic signed [tpce_pkg::POS_W-1:0] pen_v;
  } pen_frame_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [tpce_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [tpce_pkg::CFG_W-1:0]      cfg_data_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [tpce_pkg::IN_TDATA_W-1:0] s_axis_tdata;
  logic [tpce_pkg::OP_W-1:0]       s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [tpce_pkg::CODE_W-1:0]     m_axis_tdata;
  logic                            m_axis_tlast;
  logic [tpce_pkg::STATUS_W-1:0]   m_axis_tuser;

  // predictor state
  logic [tpce_pkg::CFG_W-1:0]        cfg_res;
  logic [tpce_pkg::CFG_W-1:0]        cfg_aspect;
  logic signed [tpce_pkg::CFG_W-1:0] cfg_xoff;
  logic signed [tpce_pkg::CFG_W-1:0] cfg_yoff;
  logic signed [tpce_pkg::POS_W-1:0] pen_h, pen_v, org_h, org_v, sent_x, sent_y;
  pen_frame_t                        frames [FRAME_DEPTH];
  logic [DEPTH_W-1:0]                depth;

  cmd_byte_t pending_cmds [$];
  cmd_byte_t want_cmd;
  int        fail_count = 0;
  int        idle_cycles = 0;
  int        rx_hold_left = 0;
  int        rx_stall_left = 0;
  bit        rx_idle_on = 1'b1;
  bit        tx_idle_on = 1'b1;

  text_position_command_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint round_half(input longint num, input longint den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic logic signed [tpce_pkg::POS_W-1:0] sat24(input longint v);
    if (v > tpce_pkg::POS_MAX) return tpce_pkg::POS_W'(tpce_pkg::POS_MAX);
    if (v < tpce_pkg::POS_MIN) return tpce_pkg::POS_W'(tpce_pkg::POS_MIN);
    return v[tpce_pkg::POS_W-1:0];
  endfunction

  function automatic void push_cmd(input logic [tpce_pkg::CODE_W-1:0] data, input logic last,
                                   input logic [tpce_pkg::STATUS_W-1:0] status);
    cmd_byte_t c;
    c.data   = data;
    c.last   = last;
    c.status = status;
    pending_cmds.push_back(c);
  endfunction

  function automatic void encode_word(input logic [tpce_pkg::OP_W-1:0] op,
                                      input logic signed [tpce_pkg::POS_W-1:0] mv,
                                      input logic [tpce_pkg::CODE_W-1:0] code);
    longint den, ax, ay, dx;
    logic signed [tpce_pkg::POS_W-1:0] x, y;
    case (op)
      OP_PUSH: begin
        if (depth >= DEPTH_W'(FRAME_DEPTH)) begin
          push_cmd(8'h00, 1'b1, tpce_pkg::ST_OVF);
        end else begin
          frames[depth] = '{org_h, org_v, pen_h, pen_v};
          depth++;
          org_h = pen_h;
          org_v = pen_v;
          pen_h = '0;
          pen_v = '0;
        end
      end
      OP_POP: begin
        if (depth == '0) begin
          push_cmd(8'h00, 1'b1, tpce_pkg::ST_UNF);
        end else begin
          depth--;
          org_h = frames[depth].org_h;
          org_v = frames[depth].org_v;
          pen_h = frames[depth].pen_h;
          pen_v = frames[depth].pen_v;
        end
      end
      OP_SET_H:   pen_h = mv;
      OP_MOVE_H:  pen_h = pen_h + mv;
      OP_SET_V:   pen_v = mv;
      OP_MOVE_V:  pen_v = pen_v + mv;
      OP_NEWLINE: pen_h = '0;
      OP_PRINT: begin
        if (code != 8'd0) begin
          den = (cfg_res == '0) ? 64'sd1 : longint'(cfg_res);
          ax  = longint'(pen_h) + longint'(org_h);
          ay  = longint'(pen_v) + longint'(org_v);
          x = sat24(round_half(ax * tpce_pkg::SCREEN_RES_DEF * longint'(cfg_aspect),
                               den * (64'sd1 << tpce_pkg::ASPECT_FRAC))
                    + longint'(cfg_xoff));
          y = sat24(round_half(ay * tpce_pkg::ROW_SPAN, tpce_pkg::ROW_DEN * den)
                    + longint'(cfg_yoff));
          dx = longint'(x) - longint'(sent_x);
          if (y != sent_y) begin
            push_cmd(tpce_pkg::CH_Y_ROW, 1'b0, tpce_pkg::ST_OK);
            push_cmd(y[15:8], 1'b0, tpce_pkg::ST_OK);
            push_cmd(y[7:0], 1'b0, tpce_pkg::ST_OK);
            sent_y = y;
          end
          if (dx >= 0 && dx <= 255 && code != tpce_pkg::CH_ZERO) begin
            push_cmd(tpce_pkg::CH_X_REL, 1'b0, tpce_pkg::ST_OK);
            push_cmd(dx[7:0], 1'b0, tpce_pkg::ST_OK);
            push_cmd(code, 1'b1, tpce_pkg::ST_OK);
          end else begin
            push_cmd(tpce_pkg::CH_X_ABS, 1'b0, tpce_pkg::ST_OK);
            push_cmd(x[15:8], 1'b0, tpce_pkg::ST_OK);
            push_cmd(x[7:0], 1'b0, tpce_pkg::ST_OK);
            push_cmd(tpce_pkg::CH_CHAR, 1'b0, tpce_pkg::ST_OK);
            push_cmd(code, 1'b1, tpce_pkg::ST_OK);
          end
          sent_x = x;
        end
      end
      default: ;
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_word(input logic [tpce_pkg::OP_W-1:0] op,
                           input logic [tpce_pkg::POS_W-1:0] mv,
                           input logic [tpce_pkg::CODE_W-1:0] code);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {code, mv};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    encode_word(op, mv, code);
    @(negedge clk_i);
  endtask

  task automatic send_random_word();
    logic [tpce_pkg::OP_W-1:0]   op;
    logic [tpce_pkg::POS_W-1:0]  mv;
    logic [tpce_pkg::CODE_W-1:0] code;
    int                          pick;
    pick = $urandom_range(0, 99);
    if (pick < 7)       op = OP_PUSH;
    else if (pick < 14) op = OP_POP;
    else if (pick < 21) op = OP_SET_H;
    else if (pick < 33) op = OP_MOVE_H;
    else if (pick < 39) op = OP_SET_V;
    else if (pick < 47) op = OP_MOVE_V;
    else if (pick < 52) op = OP_NEWLINE;
    else                op = OP_PRINT;
    case ($urandom_range(0, 9))
      0: mv = tpce_pkg::POS_W'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: mv = tpce_pkg::POS_W'(tpce_pkg::POS_MAX);
          1: mv = tpce_pkg::POS_W'(tpce_pkg::POS_MIN);
          2: mv = '0;
          default: mv = '1;
        endcase
      end
      default: mv = tpce_pkg::POS_W'($urandom_range(0, 6000) - 3000);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 5)       code = 8'd0;
    else if (pick < 10) code = tpce_pkg::CH_ZERO;
    else                code = tpce_pkg::CODE_W'($urandom_range(1, 255));
    send_word(op, mv, code);
  endtask

  task automatic wait_for_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [tpce_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tpce_pkg::CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [tpce_pkg::CFG_W-1:0] res,
                                input logic [tpce_pkg::CFG_W-1:0] aspect,
                                input logic [tpce_pkg::CFG_W-1:0] xoff,
                                input logic [tpce_pkg::CFG_W-1:0] yoff);
    write_reg(tpce_pkg::REG_RESOLUTION, res);
    write_reg(tpce_pkg::REG_ASPECT, aspect);
    write_reg(tpce_pkg::REG_X_OFFSET, xoff);
    write_reg(tpce_pkg::REG_Y_OFFSET, yoff);
    cfg_we_i   <= 1'b0;
    cfg_res    = res;
    cfg_aspect = aspect;
    cfg_xoff   = xoff;
    cfg_yoff   = yoff;
  endtask

  task automatic test_directed_cases();
    send_word(OP_PRINT, '0, "A");
    send_word(OP_PRINT, '0, tpce_pkg::CH_ZERO);
    send_word(OP_PRINT, '0, 8'd0);
    send_word(OP_SET_V, 24'd5000, 8'd0);
    send_word(OP_PRINT, '0, 8'd255);
    send_word(OP_MOVE_H, 24'd2000, 8'd0);
    send_word(OP_PRINT, '0, 8'd1);
    // moves wrap within 24 bits
    send_word(OP_SET_H, tpce_pkg::POS_W'(tpce_pkg::POS_MAX), 8'd0);
    send_word(OP_MOVE_H, 24'd1, 8'hff);
    send_word(OP_PRINT, '0, "E");
    send_word(OP_SET_V, tpce_pkg::POS_W'(tpce_pkg::POS_MIN), 8'd0);
    send_word(OP_MOVE_V, '1, 8'd0);
    send_word(OP_PRINT, '1, "F");
    send_word(OP_NEWLINE, '1, 8'd0);
    send_word(OP_PRINT, '0, "G");
    // pop on empty stack, then fill past full and empty it past empty
    send_word(OP_POP, '0, 8'd0);
    repeat (FRAME_DEPTH + 1) send_word(OP_PUSH, tpce_pkg::POS_W'($urandom), 8'd0);
    repeat (FRAME_DEPTH + 1) send_word(OP_POP, tpce_pkg::POS_W'($urandom), 8'd0);
    wait_for_idle();
  endtask

  task automatic test_register_extremes();
    apply_settings(16'd0, 16'hffff, 16'h7fff, 16'h8000);
    repeat (30) send_random_word();
    wait_for_idle();
    apply_settings(16'd1, 16'd0, 16'h8000, 16'h7fff);
    repeat (30) send_random_word();
    wait_for_idle();
    apply_settings(16'hffff, 16'hffff, 16'd0, 16'd0);
    repeat (30) send_random_word();
    wait_for_idle();
    repeat (2) begin
      apply_settings(tpce_pkg::CFG_W'($urandom_range(400, 2000)),
                     tpce_pkg::CFG_W'($urandom_range(2048, 8192)),
                     tpce_pkg::CFG_W'($urandom_range(0, 400) - 200),
                     tpce_pkg::CFG_W'($urandom_range(0, 400) - 200));
      repeat (30) send_random_word();
      wait_for_idle();
    end
  endtask

  task automatic test_output_backpressure();
    apply_settings(tpce_pkg::RESOLUTION_RST, tpce_pkg::ASPECT_RST, 16'd0, 16'd0);
    tx_idle_on = 1'b0;
    @(posedge clk_i);
    rx_hold_left = 400;
    @(negedge clk_i);
    repeat (12) begin
      send_word(OP_MOVE_V, tpce_pkg::POS_W'($urandom_range(0, 4000) - 2000), 8'd0);
      send_word(OP_PRINT, '0, tpce_pkg::CODE_W'($urandom_range(1, 255)));
    end
    wait_for_idle();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    repeat (5) begin
      tx_idle_on = 1'($urandom_range(0, 1));
      rx_idle_on = 1'($urandom_range(0, 1));
      repeat (20) send_random_word();
    end
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (80) send_random_word();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_res       = tpce_pkg::RESOLUTION_RST;
    cfg_aspect    = tpce_pkg::ASPECT_RST;
    cfg_xoff      = '0;
    cfg_yoff      = '0;
    pen_h         = '0;
    pen_v         = '0;
    org_h         = '0;
    org_v         = '0;
    sent_x        = '0;
    sent_y        = '0;
    depth         = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic();
    wait_for_idle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // receiver side: long hold-off on request, random stall bursts otherwise
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left  = rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left = rx_stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      rx_stall_left = $urandom_range(0, 18);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_cmds.size() == 0) begin
        $error("unexpected word: out_byte %0h last %0b status %0d",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        fail_count++;
      end else begin
        want_cmd = pending_cmds.pop_front();
        if (m_axis_tdata !== want_cmd.data) begin
          $error("out_byte: expected %0h, actual %0h", want_cmd.data, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== want_cmd.last) begin
          $error("last: expected %0b, actual %0b", want_cmd.last, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tuser !== want_cmd.status) begin
          $error("status: expected %0d, actual %0d", want_cmd.status, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
